// File: rtl/core/pnu_pkg.sv
`default_nettype none

package pnu_pkg;

  // store geometry
  localparam int NEURONS   = 1024;
  localparam int MAX_STEPS = 16;
  localparam int ADDR_W    = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  // field widths
  localparam int NEURON_W = 10;
  localparam int POT_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int DECAY_W  = 16;
  localparam int STEPS_W  = 5;
  localparam int SCALE_W  = 17;
  localparam int REFR_W   = 16;
  localparam int MEM_W    = POT_W + REFR_W;

  // stream packing
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RESTING_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_LENGTH = 3'd4;

  // register reset values
  localparam logic signed [POT_W-1:0] RESTING_RST = '0;
  localparam logic [DECAY_W-1:0]      DECAY_RST   = 16'd6554;
  localparam logic [STEPS_W-1:0]      STEPS_RST   = 5'd10;
  localparam logic [SCALE_W-1:0]      SCALE_RST   = 17'd6554;
  localparam logic [REFR_W-1:0]       REFR_RST    = 16'd4;

  // control sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_LEAK,
    ST_INTEG,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/poisson_neuron_update.sv
// Poisson spiking neuron update with refractory counter, Q16.16 fixed point.
//
// Items enter on the s_axis channel (neuron index, synaptic drive, uniform
// threshold sample, disable flag in tuser); one result per item leaves on the
// m_axis channel in the same order (index and new potential in tdata,
// updated and fired flags in tuser). Registers are written through the cfg
// channel, which is always ready; write them only while the block is idle.
//
// Per-neuron potential and refractory counter live in one synchronous RAM.
// An enabled item is read from RAM, loaded into the working registers, then
// runs h Euler substeps before the result register, where h is the clamped
// step count: every substep passes a leak state (leak product), then an
// integrate state (scaled increment with saturation). One further item is
// buffered at the input while another is computed, so an item can still be
// taken while a result waits downstream.
// After reset the RAM is swept to zero, one entry a cycle; s_axis_tready
// stays low during the sweep. A stalled m_axis holds the result register,
// and the sequencer waits in its done state until it frees up.
`default_nettype none

module poisson_neuron_update (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tdata: neuron[9:0], synaptic_input[41:10], random_sample[57:42], zero fill
  input  wire logic [pnu_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: disabled[0]
  input  wire logic [pnu_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: out_neuron[9:0], potential[41:10], zero fill
  output logic [pnu_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  // tuser: updated[0], fired[1]
  output logic [pnu_pkg::M_TUSER_W-1:0]           m_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pnu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pnu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AW = pnu_pkg::ADDR_W;
  localparam int SW = pnu_pkg::STEPS_W;
  localparam int RW = pnu_pkg::REFR_W;

  // configuration registers
  logic signed [pnu_pkg::POT_W-1:0] rest_q;
  logic [pnu_pkg::DECAY_W-1:0]      decay_q;
  logic [SW-1:0]                    steps_q;
  logic [pnu_pkg::SCALE_W-1:0]      scale_q;
  logic [pnu_pkg::REFR_W-1:0]       refr_len_q;

  // sequencer
  pnu_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_cnt_q;
  logic [SW-1:0]   cnt_q, cnt_d;

  // input buffer
  logic                               pend_vld_q;
  logic [pnu_pkg::NEURON_W-1:0]       pend_neuron_q;
  logic signed [pnu_pkg::POT_W-1:0]   pend_drive_q;
  logic [pnu_pkg::SAMPLE_W-1:0]       pend_thr_q;
  logic                               pend_dis_q;

  // item in the unit
  logic [pnu_pkg::NEURON_W-1:0]       cur_neuron_q;
  logic signed [pnu_pkg::POT_W-1:0]   drive_q;
  logic [pnu_pkg::SAMPLE_W-1:0]       thr_q;
  logic                               upd_q;
  logic                               oor_q;
  logic signed [pnu_pkg::POT_W-1:0]   x_q;
  logic [pnu_pkg::REFR_W-1:0]         refr_q;
  logic signed [33:0]                 leak_q;

  // memory
  logic [pnu_pkg::MEM_W-1:0] mem_q [pnu_pkg::NEURONS];
  logic [pnu_pkg::MEM_W-1:0] mem_rdata_q;
  logic                      mem_rd_en, mem_wr_en;
  logic [AW-1:0]             mem_rd_addr, mem_wr_addr;
  logic [pnu_pkg::MEM_W-1:0] mem_wr_data;

  // output register
  logic                            out_vld_q;
  logic [pnu_pkg::M_TDATA_W-1:0]   out_data_q;
  logic [pnu_pkg::M_TUSER_W-1:0]   out_user_q;

  logic in_acc, out_free, pend_in_range, finish;
  logic [SW-1:0] h_steps;

  // handshakes
  assign s_axis_tready = !pend_vld_q && (state_q != pnu_pkg::ST_CLEAR);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q     <= pnu_pkg::RESTING_RST;
      decay_q    <= pnu_pkg::DECAY_RST;
      steps_q    <= pnu_pkg::STEPS_RST;
      scale_q    <= pnu_pkg::SCALE_RST;
      refr_len_q <= pnu_pkg::REFR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pnu_pkg::CFG_RESTING_LEVEL:     rest_q     <= $signed(cfg_data_i[pnu_pkg::POT_W-1:0]);
        pnu_pkg::CFG_DECAY_RATE:        decay_q    <= cfg_data_i[pnu_pkg::DECAY_W-1:0];
        pnu_pkg::CFG_STEPS:             steps_q    <= cfg_data_i[SW-1:0];
        pnu_pkg::CFG_STEP_SCALE:        scale_q    <= cfg_data_i[pnu_pkg::SCALE_W-1:0];
        pnu_pkg::CFG_REFRACTORY_LENGTH: refr_len_q <= cfg_data_i[pnu_pkg::REFR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped substep count
  always_comb begin
    if (steps_q == '0) begin
      h_steps = SW'(1);
    end else if (32'(steps_q) > 32'(pnu_pkg::MAX_STEPS)) begin
      h_steps = SW'(pnu_pkg::MAX_STEPS);
    end else begin
      h_steps = steps_q;
    end
  end

  // indices past the store are reported like a skipped item, with a zero potential
  assign pend_in_range = 32'(pend_neuron_q) < 32'(pnu_pkg::NEURONS);

  // input buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else if (in_acc) begin
      pend_vld_q <= 1'b1;
    end else if (state_q == pnu_pkg::ST_LOAD) begin
      pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_neuron_q <= s_axis_tdata[9:0];
      pend_drive_q  <= $signed(s_axis_tdata[41:10]);
      pend_thr_q    <= s_axis_tdata[57:42];
      pend_dis_q    <= s_axis_tuser[0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      pnu_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(pnu_pkg::NEURONS - 1)) state_d = pnu_pkg::ST_IDLE;
      end
      pnu_pkg::ST_IDLE: begin
        if (pend_vld_q) state_d = pnu_pkg::ST_LOAD;
      end
      pnu_pkg::ST_LOAD: begin
        cnt_d = h_steps;
        if (pend_dis_q || !pend_in_range) state_d = pnu_pkg::ST_DONE;
        else state_d = pnu_pkg::ST_LEAK;
      end
      pnu_pkg::ST_LEAK: begin
        state_d = pnu_pkg::ST_INTEG;
      end
      pnu_pkg::ST_INTEG: begin
        cnt_d = cnt_q - SW'(1);
        if (cnt_q == SW'(1)) state_d = pnu_pkg::ST_DONE;
        else state_d = pnu_pkg::ST_LEAK;
      end
      pnu_pkg::ST_DONE: begin
        if (out_free) state_d = pnu_pkg::ST_IDLE;
      end
      default: state_d = pnu_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pnu_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == pnu_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // refractory and firing decision at the end of an item
  logic                        fire;
  logic [pnu_pkg::REFR_W-1:0]  refr_new;
  always_comb begin
    fire     = 1'b0;
    refr_new = refr_q;
    if (refr_q == '0) begin
      fire = x_q >= $signed({{(pnu_pkg::POT_W - pnu_pkg::SAMPLE_W){1'b0}}, thr_q});
      if (fire) refr_new = refr_len_q;
    end else begin
      refr_new = refr_q - RW'(1);
    end
  end

  // sequencer outputs
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(pend_neuron_q);
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(cur_neuron_q);
    mem_wr_data = {refr_new, x_q};
    finish      = 1'b0;
    unique case (state_q)
      pnu_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_q;
        mem_wr_data = '0;
      end
      pnu_pkg::ST_IDLE: begin
        mem_rd_en = pend_vld_q;
      end
      pnu_pkg::ST_DONE: begin
        finish    = out_free;
        mem_wr_en = out_free && upd_q;
      end
      default: ;
    endcase
  end

  // state memory
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) mem_q[mem_wr_addr] <= mem_wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) mem_rdata_q <= mem_q[mem_rd_addr];
  end

  // substep arithmetic: leak product, then scaled increment with saturation
  logic signed [32:0] diff;
  logic signed [49:0] prod_leak;
  logic signed [34:0] sum;
  logic signed [52:0] prod_inc;
  logic signed [36:0] inc;
  logic signed [37:0] x_next;
  logic signed [pnu_pkg::POT_W-1:0] x_sat;

  always_comb begin
    diff      = 33'(rest_q) - 33'(x_q);
    prod_leak = 50'(diff) * 50'($signed({1'b0, decay_q}));
    sum       = 35'(leak_q) + 35'(drive_q);
    prod_inc  = 53'(sum) * 53'($signed({1'b0, scale_q}));
    inc       = 37'(prod_inc >>> 16);
    x_next    = 38'(x_q) + 38'(inc);
    if (x_next[37:31] == '0 || x_next[37:31] == '1) begin
      x_sat = x_next[31:0];
    end else if (x_next[37]) begin
      x_sat = {1'b1, {(pnu_pkg::POT_W - 1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(pnu_pkg::POT_W - 1){1'b1}}};
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pnu_pkg::ST_LOAD: begin
        cur_neuron_q <= pend_neuron_q;
        drive_q      <= pend_drive_q;
        thr_q        <= pend_thr_q;
        upd_q        <= !pend_dis_q && pend_in_range;
        oor_q        <= !pend_in_range;
        x_q          <= $signed(mem_rdata_q[pnu_pkg::POT_W-1:0]);
        refr_q       <= mem_rdata_q[pnu_pkg::MEM_W-1:pnu_pkg::POT_W];
      end
      pnu_pkg::ST_LEAK:  leak_q <= 34'(prod_leak >>> 16);
      pnu_pkg::ST_INTEG: x_q    <= x_sat;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= {6'b0, (oor_q ? {pnu_pkg::POT_W{1'b0}} : x_q), cur_neuron_q};
      out_user_q <= {upd_q && fire, upd_q};
    end
  end

  // checks
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en && mem_wr_en))
    else $error("memory read and write in the same cycle");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnu_pkg::ST_LOAD) |-> $past(mem_rd_en))
    else $error("load without a preceding memory read");

  a_load_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnu_pkg::ST_LOAD) |-> pend_vld_q)
    else $error("load with an empty input buffer");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnu_pkg::ST_LEAK || state_q == pnu_pkg::ST_INTEG) |-> (cnt_q != '0))
    else $error("substep counter empty while integrating");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (!out_vld_q || m_axis_tready))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: verif/tb_poisson_neuron_update.sv
`default_nettype none

module tb_poisson_neuron_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SETTLE      = 2 * pnu_pkg::MAX_STEPS + 8;
  localparam longint POT_MAX     = 64'sd2147483647;
  localparam longint POT_MIN     = -64'sd2147483648;

  // one expected result item
  typedef struct packed {
    logic [pnu_pkg::NEURON_W-1:0] neuron;
    logic                         updated;
    logic                         fired;
    logic [pnu_pkg::POT_W-1:0]    potential;
  } update_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic [pnu_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [pnu_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pnu_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic [pnu_pkg::M_TUSER_W-1:0]  m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [pnu_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [pnu_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  poisson_neuron_update u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow registers and neuron stores
  logic signed [pnu_pkg::POT_W-1:0] sh_resting;
  logic [pnu_pkg::DECAY_W-1:0]      sh_decay;
  logic [pnu_pkg::STEPS_W-1:0]      sh_steps;
  logic [pnu_pkg::SCALE_W-1:0]      sh_scale;
  logic [pnu_pkg::REFR_W-1:0]       sh_refr;
  logic signed [pnu_pkg::POT_W-1:0] pot_mem [pnu_pkg::NEURONS];
  logic [pnu_pkg::REFR_W-1:0]       refr_mem [pnu_pkg::NEURONS];

  update_t pending_updates[$];
  int      mismatches    = 0;
  int      items_sent    = 0;
  int      items_checked = 0;
  int      spikes_seen   = 0;
  int      skips_seen    = 0;
  int      settings_used = 1;
  int      cycles        = 0;
  bit      calm          = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_updates.size());
    $display("== FAIL ==");
    $finish;
  end

  // neuron state after reset
  initial begin
    sh_resting = pnu_pkg::RESTING_RST;
    sh_decay   = pnu_pkg::DECAY_RST;
    sh_steps   = pnu_pkg::STEPS_RST;
    sh_scale   = pnu_pkg::SCALE_RST;
    sh_refr    = pnu_pkg::REFR_RST;
    for (int i = 0; i < pnu_pkg::NEURONS; i++) begin
      pot_mem[i]  = '0;
      refr_mem[i] = '0;
    end
  end

  // euler integration, threshold test and refractory bookkeeping for one item
  function automatic update_t predict_update(input logic [pnu_pkg::NEURON_W-1:0] n,
                                             input logic signed [pnu_pkg::POT_W-1:0] drive,
                                             input logic [pnu_pkg::SAMPLE_W-1:0] sample,
                                             input logic dis);
    update_t r;
    longint  x;
    longint  leak;
    longint  inc;
    int      h;
    r.neuron    = n;
    r.updated   = 1'b0;
    r.fired     = 1'b0;
    r.potential = '0;
    if (dis) begin
      r.potential = pot_mem[n];
      return r;
    end
    h = (sh_steps == 0) ? 1 :
        (sh_steps > pnu_pkg::MAX_STEPS) ? pnu_pkg::MAX_STEPS : int'(sh_steps);
    x = longint'(pot_mem[n]);
    for (int i = 0; i < h; i++) begin
      leak = ((longint'(sh_resting) - x) * longint'(sh_decay)) >>> 16;
      inc  = ((leak + longint'(drive)) * longint'(sh_scale)) >>> 16;
      x    = x + inc;
      if (x > POT_MAX) x = POT_MAX;
      else if (x < POT_MIN) x = POT_MIN;
    end
    if (refr_mem[n] == 0) begin
      if (x >= longint'(sample)) begin
        r.fired     = 1'b1;
        refr_mem[n] = sh_refr;
      end
    end else begin
      refr_mem[n] = refr_mem[n] - 1'b1;
    end
    pot_mem[n]  = x[pnu_pkg::POT_W-1:0];
    r.updated   = 1'b1;
    r.potential = x[pnu_pkg::POT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // result sink with random backpressure
  always @(posedge clk_i) begin
    if (calm) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) >= 28);
  end

  // result checker
  always @(posedge clk_i) begin
    update_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected result neuron %0d", m_axis_tdata[9:0]));
      end else begin
        want = pending_updates.pop_front();
        items_checked++;
        if (m_axis_tdata[9:0] !== want.neuron)
          report_mismatch($sformatf("neuron got %0d want %0d",
                                    m_axis_tdata[9:0], want.neuron));
        if (m_axis_tuser[0] !== want.updated)
          report_mismatch($sformatf("neuron %0d updated got %b want %b",
                                    want.neuron, m_axis_tuser[0], want.updated));
        if (m_axis_tuser[1] !== want.fired)
          report_mismatch($sformatf("neuron %0d fired got %b want %b",
                                    want.neuron, m_axis_tuser[1], want.fired));
        if (m_axis_tdata[41:10] !== want.potential)
          report_mismatch($sformatf("neuron %0d potential got %h want %h",
                                    want.neuron, m_axis_tdata[41:10], want.potential));
        if (want.fired) spikes_seen++;
        if (!want.updated) skips_seen++;
      end
    end
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_update(input logic [pnu_pkg::NEURON_W-1:0] n,
                             input logic [pnu_pkg::POT_W-1:0] drive,
                             input logic [pnu_pkg::SAMPLE_W-1:0] sample, input logic dis);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) gap++;
      if ($urandom_range(0, 49) == 0) gap += $urandom_range(1, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(pnu_pkg::S_TDATA_W - pnu_pkg::NEURON_W - pnu_pkg::POT_W
                        - pnu_pkg::SAMPLE_W){1'b0}}, sample, drive, n};
    s_axis_tuser  <= dis;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_updates.push_back(predict_update(n, drive, sample, dis));
    items_sent++;
  endtask

  // hold the input until every outstanding result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_updates.size() != 0);
  endtask

  task automatic write_reg(input logic [pnu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pnu_pkg::CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pnu_pkg::CFG_RESTING_LEVEL:     sh_resting = data;
      pnu_pkg::CFG_DECAY_RATE:        sh_decay   = data[pnu_pkg::DECAY_W-1:0];
      pnu_pkg::CFG_STEPS:             sh_steps   = data[pnu_pkg::STEPS_W-1:0];
      pnu_pkg::CFG_STEP_SCALE:        sh_scale   = data[pnu_pkg::SCALE_W-1:0];
      pnu_pkg::CFG_REFRACTORY_LENGTH: sh_refr    = data[pnu_pkg::REFR_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // reprogram all registers once the block is idle
  task automatic set_config(input logic [31:0] rest, input logic [15:0] decay,
                            input logic [4:0] nsteps, input logic [16:0] scale,
                            input logic [15:0] refr);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(pnu_pkg::CFG_RESTING_LEVEL, rest);
    write_reg(pnu_pkg::CFG_DECAY_RATE, {16'b0, decay});
    write_reg(pnu_pkg::CFG_STEPS, {27'b0, nsteps});
    write_reg(pnu_pkg::CFG_STEP_SCALE, {15'b0, scale});
    write_reg(pnu_pkg::CFG_REFRACTORY_LENGTH, {16'b0, refr});
    settings_used++;
  endtask

  // reset register values, store clear, first spike and refractory countdown
  task automatic test_defaults();
    send_update(10'd0, 32'h0000_0000, 16'h0000, 1'b0);
    send_update(10'd0, 32'h0000_0000, 16'h0000, 1'b0);
    send_update(10'd1023, 32'h7fff_ffff, 16'hffff, 1'b0);
    send_update(10'd1, 32'h8000_0000, 16'h0000, 1'b0);
    send_update(10'd1023, $urandom, 16'(($urandom)), 1'b1);
    send_update(10'h2aa, 32'h0001_0000, 16'h8000, 1'b0);
  endtask

  // register extremes: clamped step counts, scale above one, zero and long refractory
  task automatic test_config_extremes();
    set_config(32'h7fff_ffff, 16'hffff, 5'd0, 17'h1ffff, 16'd0);
    send_update(10'd2, 32'h0000_0000, 16'h0000, 1'b0);
    send_update(10'd2, 32'h0000_0000, 16'h0000, 1'b0);
    send_update(10'd2, 32'h7fff_ffff, 16'hffff, 1'b0);
    send_update(10'd3, 32'h7fff_ffff, 16'hffff, 1'b0);
    set_config(32'h8000_0000, 16'd0, 5'd31, 17'h10000, 16'hffff);
    send_update(10'd4, 32'h8000_0000, 16'h0000, 1'b0);
    send_update(10'd4, 32'h8000_0000, 16'h0000, 1'b0);
    send_update(10'd5, 32'h0000_8000, 16'h0000, 1'b0);
    send_update(10'd5, 32'h0000_8000, 16'h0000, 1'b0);
    set_config(32'h0000_0000, 16'd6554, 5'd16, 17'd0, 16'd1);
    send_update(10'd5, 32'h7fff_ffff, 16'h0000, 1'b0);
    send_update(10'd6, 32'h0000_0000, 16'h0000, 1'b1);
    set_config(32'h0000_0000, 16'd32768, 5'd1, 17'd65536, 16'd2);
    send_update(10'd7, 32'h0000_8000, 16'h7fff, 1'b0);
    send_update(10'd7, 32'hffff_8000, 16'h0001, 1'b0);
  endtask

  // random register settings, mostly in a useful range
  task automatic random_config();
    logic [31:0] rest;
    logic [15:0] decay;
    logic [4:0]  nsteps;
    logic [16:0] scale;
    logic [15:0] refr;
    case ($urandom_range(0, 3))
      0:       rest = '0;
      1:       rest = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      2:       rest = $urandom;
      default: rest = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
    decay  = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 20000));
    nsteps = $urandom_range(0, 4) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 10));
    scale  = $urandom_range(0, 3) == 0 ? 17'($urandom)
                                       : 17'(65536 / int'(nsteps == 0 ? 1 : nsteps));
    refr   = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8));
    set_config(rest, decay, nsteps, scale, refr);
  endtask

  // random items on a small hot set of neurons plus the full index range
  task automatic test_random(input int phases, input int per_phase);
    logic [pnu_pkg::NEURON_W-1:0] n;
    logic [pnu_pkg::POT_W-1:0]    drive;
    for (int p = 0; p < phases; p++) begin
      random_config();
      calm = (p == 0);
      for (int k = 0; k < per_phase; k++) begin
        if (k == per_phase / 2 && p[0]) wait_drained();
        n = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 15)) : 10'($urandom);
        case ($urandom_range(0, 3))
          0, 1:    drive = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
          2:       drive = $urandom;
          default: begin
            case ($urandom_range(0, 4))
              0:       drive = 32'h7fff_ffff;
              1:       drive = 32'h8000_0000;
              2:       drive = 32'h0001_0000;
              3:       drive = 32'hffff_0000;
              default: drive = '0;
            endcase
          end
        endcase
        send_update(n, drive, 16'($urandom), $urandom_range(0, 9) == 0);
      end
    end
    calm = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_config_extremes();
    test_random(10, 124);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d items over %0d register settings, %0d spikes, %0d skipped",
             items_checked, settings_used, spikes_seen, skips_seen);
    $display("directed extremes and random drive with stalls on both streams");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/pnu_pkg.sv
rtl/core/poisson_neuron_update.sv
verif/tb_poisson_neuron_update.sv
